/* src/assert_macros.svh */
// Assertion macros for the polar Gaussian deviate generator.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is low.
`define GPBM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gpbm assertion failed");

// Clocked check that also holds during reset.
`define GPBM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("gpbm assertion failed");

`endif

/* src/gpbm_pkg.sv */
// Package for the polar Gaussian deviate generator: payload types,
// register indexes and arithmetic constants. No dependencies.
package gpbm_pkg;

    localparam int UNIFORM_BITS  = 16;
    localparam int FRAC_BITS     = UNIFORM_BITS - 1;
    localparam int LOG_FRAC_BITS = 24;
    localparam logic [30:0] LN2X2_Q30 = 31'd1488522236;

    localparam logic [7:0] CFG_MEAN_OFFSET = 8'd0;
    localparam logic [7:0] CFG_STD_SCALE   = 8'd1;

    typedef struct packed {
        logic signed [UNIFORM_BITS-1:0] uniform_a;
        logic signed [UNIFORM_BITS-1:0] uniform_b;
    } gpbm_sample_t;

    typedef struct packed {
        logic signed [31:0] deviate;
        logic               last_of_pair;
    } gpbm_result_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [15:0] mag_a;
        logic        neg_a;
        logic [15:0] mag_b;
        logic        neg_b;
        logic [30:0] mant;   // radius normalized to Q1.30
        logic [4:0]  sft;    // s = 2F - k, 1..30
    } gpbm_job_t;

    typedef struct packed {
        logic        we;
        logic [7:0]  index;
        logic [15:0] data;
    } gpbm_cfg_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } gpbm_queue_status_t;

endpackage

/* src/gaussian_polar_box_muller_top.sv */
// Top level of the polar Gaussian deviate generator: front end, item
// queue and iterative back end. Uses gpbm_pkg and assert_macros.svh.
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-------------------------------
//  sample   | start, busy, sample              | taken when start && !busy
//  result   | result_strobe, result            | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index, | written when valid && ready
//           | cfg_data                         |
//
// The front takes a pair every cycle while its stage can advance; a rejected
// pair leaves the stage in the next cycle and gives no item downstream.
// The back takes one item at a time through a pop, 24 log2 rounds, one
// scale multiply, 31 divide and 28 square-root steps, then a product, scale
// and output step per deviate. busy rises when the front stage and both
// queue entries are taken. Reset loads mean 0 and scale 1.0.
module gaussian_polar_box_muller_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  gpbm_pkg::gpbm_sample_t sample,
    output logic                   result_strobe,
    output gpbm_pkg::gpbm_result_t result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [7:0]             cfg_index,
    input  logic [15:0]            cfg_data
);
    import gpbm_pkg::*;
`include "assert_macros.svh"

    gpbm_job_t          push_job, head;
    gpbm_queue_status_t q_status;
    gpbm_cfg_t          cfg;
    logic               push, pop;

    // Registers never stall a write.
    assign cfg_ready = 1'b1;
    assign cfg.we    = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    gpbm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sample (sample),
        .busy   (busy),
        .q_full (q_status.full),
        .push   (push),
        .job    (push_job)
    );

    gpbm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    gpbm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_status.empty),
        .head          (head),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // Occupancy never exceeds the two entries.
    `GPBM_ASSERT_ALWAYS(a_queue_bound, q_status.count != 2'd3)
    // Stall only when the queue is full.
    `GPBM_ASSERT(a_busy_full, busy |-> q_status.full)
    // First deviate is followed by the second, flagged as last of the pair.
    `GPBM_ASSERT(a_pair_order, (result_strobe && !result.last_of_pair) |->
        ##3 (result_strobe && result.last_of_pair))
endmodule

/* src/gpbm_front.sv */
// Front end: accepts sample pairs, forms the squared radius, rejects
// pairs outside the unit disk and normalizes the rest. Uses gpbm_pkg.
module gpbm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  gpbm_pkg::gpbm_sample_t sample,
    output logic                  busy,
    input  logic                  q_full,
    output logic                  push,
    output gpbm_pkg::gpbm_job_t   job
);
    import gpbm_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [15:0] mag_a_reg, mag_b_reg;
    logic        neg_a_reg, neg_b_reg;
    logic [31:0] radius_reg;
    logic        accept, reject, leaving;
    logic [15:0] mag_a, mag_b;
    logic [4:0]  top_bit;
    logic [4:0]  lshift;

    assign mag_a = sample.uniform_a[15] ? (~sample.uniform_a + 16'd1) : sample.uniform_a;
    assign mag_b = sample.uniform_b[15] ? (~sample.uniform_b + 16'd1) : sample.uniform_b;

    assign reject  = (radius_reg == 32'd0) || (radius_reg[31:30] != 2'b00);
    assign leaving = s1_valid_reg && (reject || !q_full);
    assign busy    = s1_valid_reg && !leaving;
    assign accept  = start && !busy;
    assign push    = s1_valid_reg && !reject && !q_full;

    // Find the top set bit of the radius.
    always_comb
    begin
        top_bit = 5'd0;
        for (int i = 0; i < 30; i++)
        begin
            if (radius_reg[i])
            begin
                top_bit = 5'(i);
            end
        end
    end

    assign lshift    = 5'd30 - top_bit;
    assign job.mag_a = mag_a_reg;
    assign job.neg_a = neg_a_reg;
    assign job.mag_b = mag_b_reg;
    assign job.neg_b = neg_b_reg;
    assign job.mant  = radius_reg[30:0] << lshift;
    assign job.sft   = lshift;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (leaving)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_a_reg  <= mag_a;
            mag_b_reg  <= mag_b;
            neg_a_reg  <= sample.uniform_a[15];
            neg_b_reg  <= sample.uniform_b[15];
            radius_reg <= 32'(mag_a) * 32'(mag_a) + 32'(mag_b) * 32'(mag_b);
        end
    end
endmodule

/* src/gpbm_queue.sv */
// Two-entry queue of classified items between the front and the back.
// Uses gpbm_pkg.
module gpbm_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  gpbm_pkg::gpbm_job_t          push_job,
    input  logic                         pop,
    output gpbm_pkg::gpbm_job_t          head,
    output gpbm_pkg::gpbm_queue_status_t status
);
    import gpbm_pkg::*;

    gpbm_job_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign head          = entry_reg[rd_ptr_reg];
    assign status.count  = count_reg;
    assign status.full   = (count_reg == 2'd2);
    assign status.empty  = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end
endmodule

/* src/gpbm_back.sv */
// Back end: iterative log2, scale, divide and square root, then two
// scaled deviates per item. Holds the configuration registers. Uses gpbm_pkg.
module gpbm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gpbm_pkg::gpbm_cfg_t    cfg,
    input  logic                  q_empty,
    input  gpbm_pkg::gpbm_job_t   head,
    output logic                  pop,
    output logic                  result_strobe,
    output gpbm_pkg::gpbm_result_t result
);
    import gpbm_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LOG    = 8'b0000_0010,
        ST_MULQ   = 8'b0000_0100,
        ST_DIV    = 8'b0000_1000,
        ST_SQRT   = 8'b0001_0000,
        ST_DPROD  = 8'b0010_0000,
        ST_DSCALE = 8'b0100_0000,
        ST_DOUT   = 8'b1000_0000
    } back_state_t;

    back_state_t  state_reg, state_next;
    logic [15:0]  mean_reg, scale_reg;
    gpbm_job_t    job_reg;
    logic [4:0]   cnt_reg;
    logic [30:0]  y_reg;
    logic [23:0]  frac_reg;
    logic [30:0]  rem_reg;
    logic [30:0]  num_reg;
    logic [30:0]  quo_reg;
    logic [55:0]  x_reg;
    logic [28:0]  srem_reg;
    logic [27:0]  root_reg;
    logic [44:0]  d_reg;
    logic [45:0]  ys_reg;
    logic         sel_reg;
    logic         strobe_reg;
    gpbm_result_t result_reg;

    logic [61:0]  sq_prod;
    logic [31:0]  sq_t;
    logic [28:0]  lg;
    logic [59:0]  q_prod;
    logic [29:0]  q_val;
    logic [60:0]  numer;
    logic [31:0]  div_trial;
    logic         div_bit;
    logic [30:0]  quo_next;
    logic [30:0]  srt_cur;
    logic [30:0]  srt_trial;
    logic [15:0]  mag;
    logic [43:0]  mg_prod;
    logic [3:0]   rsh;
    logic [44:0]  half;
    logic [44:0]  d_val;
    logic [60:0]  sc_prod;
    logic signed [47:0] dev_val;

    assign pop           = (state_reg == ST_IDLE) && !q_empty;
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // One squaring round of the log2 fraction.
    assign sq_prod = y_reg * y_reg;
    assign sq_t    = sq_prod[61:30];

    // -2 ln r in Q24 from -log2 r.
    assign lg     = {job_reg.sft, 24'd0} - {5'd0, frac_reg};
    assign q_prod = lg * LN2X2_Q30;
    assign q_val  = 30'((q_prod + 60'd536870912) >> 30);
    assign numer  = 61'(q_val) << (5'd30 + {4'd0, job_reg.sft[0]});

    // One restoring division step.
    assign div_trial = {rem_reg, num_reg[30]};
    assign div_bit   = (div_trial >= {1'b0, job_reg.mant});
    assign quo_next  = {quo_reg[29:0], div_bit};

    // One digit of the integer square root.
    assign srt_cur   = {srem_reg[28:0], x_reg[55:54]};
    assign srt_trial = {1'b0, root_reg, 2'b01};

    // Deviate datapath.
    assign mag     = sel_reg ? job_reg.mag_a : job_reg.mag_b;
    assign mg_prod = mag * root_reg;
    assign rsh     = 4'd15 - job_reg.sft[4:1];
    assign half    = (rsh != 4'd0) ? (45'd1 << (rsh - 4'd1)) : 45'd0;
    assign d_val   = ({1'b0, mg_prod} + half) >> rsh;
    assign sc_prod = 61'(d_reg) * 61'(scale_reg);

    always_comb
    begin
        logic signed [47:0] mag_s;
        logic signed [47:0] mu_s;
        mag_s = signed'({2'b00, ys_reg});
        mu_s  = signed'({{24{mean_reg[15]}}, mean_reg, 8'd0});
        if (sel_reg ? job_reg.neg_a : job_reg.neg_b)
        begin
            dev_val = mu_s - mag_s;
        end
        else
        begin
            dev_val = mu_s + mag_s;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (!q_empty) state_next = ST_LOG;
            ST_LOG:    if (cnt_reg == 5'd23) state_next = ST_MULQ;
            ST_MULQ:   state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == 5'd30) state_next = ST_SQRT;
            ST_SQRT:   if (cnt_reg == 5'd27) state_next = ST_DPROD;
            ST_DPROD:  state_next = ST_DSCALE;
            ST_DSCALE: state_next = ST_DOUT;
            ST_DOUT:   state_next = sel_reg ? ST_IDLE : ST_DPROD;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            mean_reg   <= 16'd0;
            scale_reg  <= 16'd256;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == ST_DOUT);
            if (cfg.we && cfg.index == CFG_MEAN_OFFSET)
            begin
                mean_reg <= cfg.data;
            end
            if (cfg.we && cfg.index == CFG_STD_SCALE)
            begin
                scale_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg  <= head;
                y_reg    <= head.mant;
                frac_reg <= 24'd0;
                cnt_reg  <= 5'd0;
                sel_reg  <= 1'b0;
            end
            ST_LOG:
            begin
                frac_reg <= {frac_reg[22:0], sq_t[31]};
                y_reg    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                cnt_reg  <= cnt_reg + 5'd1;
            end
            ST_MULQ:
            begin
                rem_reg <= {1'b0, numer[60:31]};
                num_reg <= numer[30:0];
                quo_reg <= 31'd0;
                cnt_reg <= 5'd0;
            end
            ST_DIV:
            begin
                rem_reg <= div_bit ? 31'(div_trial - {1'b0, job_reg.mant}) : div_trial[30:0];
                num_reg <= {num_reg[29:0], 1'b0};
                quo_reg <= quo_next;
                if (cnt_reg == 5'd30)
                begin
                    x_reg    <= {1'b0, quo_next, 24'd0};
                    srem_reg <= 29'd0;
                    root_reg <= 28'd0;
                    cnt_reg  <= 5'd0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                end
            end
            ST_SQRT:
            begin
                if (srt_cur >= srt_trial)
                begin
                    srem_reg <= 29'(srt_cur - srt_trial);
                    root_reg <= {root_reg[26:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srt_cur[28:0];
                    root_reg <= {root_reg[26:0], 1'b0};
                end
                x_reg   <= {x_reg[53:0], 2'b00};
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_DPROD:
            begin
                d_reg <= d_val;
            end
            ST_DSCALE:
            begin
                ys_reg <= 46'((sc_prod + 61'd32768) >> 16);
            end
            ST_DOUT:
            begin
                if (dev_val > 48'sd2147483647)
                begin
                    result_reg.deviate <= 32'sh7FFF_FFFF;
                end
                else if (dev_val < -48'sd2147483648)
                begin
                    result_reg.deviate <= 32'sh8000_0000;
                end
                else
                begin
                    result_reg.deviate <= dev_val[31:0];
                end
                result_reg.last_of_pair <= sel_reg;
                sel_reg <= 1'b1;
            end
            default:
            begin
                cnt_reg <= 5'd0;
            end
        endcase
    end
endmodule

/* test/tb_gaussian_polar_box_muller_top.sv */
// Testbench for gaussian_polar_box_muller_top: drives sample pairs and register
// writes, predicts each deviate pair in fixed point and checks the result stream.
// Depends on gpbm_pkg and the top level only.
module tb_gaussian_polar_box_muller_top;
    import gpbm_pkg::*;

    // Deviate predictor and store of expected deviates, in arrival order.
    class deviate_scoreboard;
        logic [15:0]  mean_reg;
        logic [15:0]  scale_reg;
        gpbm_result_t pending_q[$];
        int           mismatches;

        function new();
            mean_reg   = 16'd0;
            scale_reg  = 16'd256;
            mismatches = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [15:0] data);
            if (idx == CFG_MEAN_OFFSET)
                mean_reg = data;
            else if (idx == CFG_STD_SCALE)
                scale_reg = data;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        // Fraction of log2 of a Q1.30 mantissa, one bit per squaring round.
        function longint unsigned log2_fraction(longint unsigned mant);
            longint unsigned y;
            longint unsigned f;
            y = mant;
            f = 0;
            for (int i = 0; i < LOG_FRAC_BITS; i++)
            begin
                y = (y * y) >> 30;
                f <<= 1;
                if (y >= (64'd1 << 31))
                begin
                    f |= 1;
                    y >>= 1;
                end
            end
            return f;
        endfunction

        function logic [31:0] scale_deviate(longint unsigned mag, bit neg,
                                            longint unsigned g, int sh);
            longint unsigned d;
            longint unsigned y;
            longint          val;
            d   = (mag * g + ((sh != 0) ? (64'd1 << (sh - 1)) : 64'd0)) >> sh;
            y   = (d * scale_reg + (64'd1 << 15)) >> 16;
            val = neg ? -longint'(y) : longint'(y);
            val += longint'($signed(mean_reg)) * 256;
            if (val > 64'sd2147483647)
                val = 64'sd2147483647;
            if (val < -64'sd2147483648)
                val = -64'sd2147483648;
            return val[31:0];
        endfunction

        // Note an accepted pair and queue the deviates it must produce.
        function void note_sample(gpbm_sample_t smp);
            logic [15:0]     raw_a;
            logic [15:0]     raw_b;
            longint unsigned mag_a;
            longint unsigned mag_b;
            longint unsigned radius;
            longint unsigned mant;
            longint unsigned lg;
            longint unsigned q;
            longint unsigned v;
            longint unsigned g;
            int              k;
            int              s;
            int              sh;
            gpbm_result_t    res;
            raw_a  = smp.uniform_a;
            raw_b  = smp.uniform_b;
            mag_a  = raw_a[15] ? (64'd65536 - raw_a) : raw_a;
            mag_b  = raw_b[15] ? (64'd65536 - raw_b) : raw_b;
            radius = mag_a * mag_a + mag_b * mag_b;
            // Drop pairs outside the open unit disc or at the origin.
            if (radius == 0 || radius >= (64'd1 << (2 * FRAC_BITS)))
                return;
            k = 0;
            while (k < 63 && (radius >> (k + 1)) != 0)
                k++;
            s    = 2 * FRAC_BITS - k;
            mant = (k >= 30) ? (radius >> (k - 30)) : (radius << (30 - k));
            lg   = (longint'(s) << LOG_FRAC_BITS) - log2_fraction(mant);
            q    = (lg * longint'(LN2X2_Q30) + (64'd1 << 29)) >> 30;
            v    = (q << (30 + (s & 1))) / mant;
            g    = int_sqrt(v << 24);
            sh   = FRAC_BITS - (s >> 1);
            res.deviate      = scale_deviate(mag_b, raw_b[15], g, sh);
            res.last_of_pair = 1'b0;
            pending_q.push_back(res);
            res.deviate      = scale_deviate(mag_a, raw_a[15], g, sh);
            res.last_of_pair = 1'b1;
            pending_q.push_back(res);
        endfunction

        function void check_result(gpbm_result_t got);
            gpbm_result_t want;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected deviate %0d last %0b",
                             got.deviate, got.last_of_pair);
                return;
            end
            want = pending_q.pop_front();
            if (got.deviate !== want.deviate || got.last_of_pair !== want.last_of_pair)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("deviate mismatch: expected %0d last %0b, got %0d last %0b",
                             want.deviate, want.last_of_pair,
                             got.deviate, got.last_of_pair);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    gpbm_sample_t sample;
    logic         result_strobe;
    gpbm_result_t result;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [15:0]  cfg_data;

    deviate_scoreboard sb = new();

    gaussian_polar_box_muller_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sample        (sample),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Check every strobed deviate; outputs are read before the edge updates them.
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            sb.check_result(result);
    end

    // Hold start and the pair until the block takes it. Start stays high when
    // the next item follows without a gap, so it is never dropped and raised
    // within one step.
    task automatic send_sample(logic [15:0] a, logic [15:0] b);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start            <= 1'b1;
        sample.uniform_a <= a;
        sample.uniform_b <= b;
        do
            @(posedge clk);
        while (busy);
        sb.note_sample({a, b});
    endtask

    // Let the block drain: every expected deviate out, then cover the back-end latency.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Hold valid high after the write; the caller drops it.
    task automatic write_reg(logic [7:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(logic [15:0] mu, logic [15:0] sigma);
        wait_idle();
        write_reg(CFG_MEAN_OFFSET, mu);
        write_reg(CFG_STD_SCALE, sigma);
        cfg_valid <= 1'b0;
    endtask

    // Mostly uniform pairs (most fall in the disc), some tiny radii for the
    // deep shifts, some values at the ends of the range.
    task automatic send_random(int count);
        logic [15:0] a;
        logic [15:0] b;
        int          mode;
        int          lim;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            a    = 16'($urandom());
            b    = 16'($urandom());
            if (mode >= 7 && mode <= 8)
            begin
                lim = (1 << $urandom_range(0, 10)) - 1;
                a   = 16'($urandom_range(0, 2 * lim) - lim);
                b   = 16'($urandom_range(0, 2 * lim) - lim);
            end
            else if (mode == 9)
            begin
                a = $urandom_range(0, 1) ? 16'h8001 : 16'h7fff;
                b = 16'($urandom_range(0, 3) - 1);
            end
            send_sample(a, b);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs under the reset config: rejections at the origin, at
        // minus one and on or outside the unit circle; extremes and tiny radii.
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h0000);
        send_sample(16'h0000, 16'h8001);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'h0000, 16'hffff);
        send_sample(16'hffff, 16'h0001);
        send_sample(16'd23170, 16'd23170);
        send_sample(-16'sd23170, 16'd23170);
        send_sample(16'h4000, 16'hc000);
        send_sample(16'h5555, 16'h2aaa);
        send_sample(16'h0003, 16'h0002);

        // Saturation: widest scale with both mean extremes.
        set_config(16'h7fff, 16'hffff);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'hffff, 16'hffff);
        send_sample(16'h7fff, 16'h0001);
        set_config(16'h8000, 16'hffff);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'hffff, 16'h0001);
        send_sample(16'h4000, 16'hc000);
        set_config(16'h0000, 16'h0000);
        send_sample(16'h1234, 16'hedcb);

        send_random(150);
        set_config(16'h0000, 16'h0100);
        send_random(150);
        set_config(16'($urandom()), 16'($urandom()));
        send_random(120);
        set_config(16'h8000, 16'h0000);
        send_random(60);
        set_config(16'h7fff, 16'h0001);
        send_random(60);
        set_config(16'($urandom()), 16'($urandom_range(0, 1023)));
        send_random(160);

        wait_idle();
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
